// ===== sv/dcq_pkg.sv =====
// types and constants shared by the deferred-call queue block
// no dependencies
`default_nettype none

package dcq_pkg;

    localparam int LEVEL_W = 8;
    localparam int KEY_W   = 32;
    localparam int ARG_W   = 32;
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOWER      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RAISE_DISP = 3'd4;

    localparam logic [LEVEL_W-1:0] DISPATCH_RESET = 8'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [ARG_W-1:0]   first_argument;
        logic [ARG_W-1:0]   second_argument;
        logic [LEVEL_W-1:0] new_level;
    } in_item_t;

    typedef struct packed {
        logic               done_flag;
        logic               queue_full;
        logic [LEVEL_W-1:0] previous_level;
        logic               entry_valid;
        logic [KEY_W-1:0]   entry_key;
        logic [ARG_W-1:0]   entry_first;
        logic [ARG_W-1:0]   entry_second;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ARG_W-1:0] first;
        logic [ARG_W-1:0] second;
    } slot_t;

endpackage

`default_nettype wire

// ===== sv/deferred_call_queue_with_level_gate.sv =====
// Raise, lower without drain, unused kinds and inserts into an empty queue give their
// one item in the cycle after start; busy stays low. Insert and remove scan the queue
// one slot a cycle through the memory read port; a remove that closes the gap also
// moves each later entry down by one slot. A drain gives one item a cycle, occupancy
// items in all. Results cannot be stalled. Reset clears occupancy, the current level
// (0) and the dispatch gate (2); slot storage is not cleared.
// depends on dcq_pkg and dcq_ram
`default_nettype none

module deferred_call_queue_with_level_gate
    import dcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire in_item_t           cmd,
    output logic                    result_valid,
    output out_item_t               result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEVEL_W-1:0] cfg_data
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OW-1:0] OCC_FULL = OW'(QUEUE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_DRAIN  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic [OW-1:0]      occ_reg, occ_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] dispatch_reg;
    in_item_t           cmd_reg, cmd_next;
    logic               strobe_reg, strobe_next;
    out_item_t          result_reg, result_next;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    slot_t              ram_wdata;
    logic [IW-1:0]      ram_raddr;
    slot_t              ram_rdata;

    logic               hit;
    logic               at_end;

    dcq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit: in search, shift and drain, read data belongs to slot scan_reg
    assign hit    = (ram_rdata.key == cmd_reg.key);
    assign at_end = ((OW'(scan_reg) + OW'(1)) == occ_reg);

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = strobe_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        occ_next    = occ_reg;
        level_next  = level_reg;
        cmd_next    = cmd_reg;
        strobe_next = 1'b0;
        result_next = '0;
        ram_we      = 1'b0;
        ram_waddr   = occ_reg[IW-1:0];
        ram_wdata   = '{key: cmd_reg.key, first: cmd_reg.first_argument,
                        second: cmd_reg.second_argument};
        ram_raddr   = scan_reg + IW'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (start)
                begin
                    cmd_next  = cmd;
                    scan_next = '0;
                    ram_wdata = '{key: cmd.key, first: cmd.first_argument,
                                  second: cmd.second_argument};
                    result_next.last = 1'b1;
                    case (cmd.kind)
                        KIND_INSERT:
                        begin
                            if (cmd.key == '0)
                            begin
                                strobe_next = 1'b1;
                            end
                            else if (occ_reg == '0)
                            begin
                                ram_we                = 1'b1;
                                occ_next              = OW'(1);
                                strobe_next           = 1'b1;
                                result_next.done_flag = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        KIND_RAISE:
                        begin
                            level_next                 = cmd.new_level;
                            strobe_next                = 1'b1;
                            result_next.previous_level = level_reg;
                        end
                        KIND_LOWER:
                        begin
                            level_next = cmd.new_level;
                            if ((cmd.new_level < dispatch_reg) && (occ_reg != '0))
                            begin
                                result_next.last = 1'b0;
                                state_next       = ST_DRAIN;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                            end
                        end
                        KIND_RAISE_DISP:
                        begin
                            level_next                 = dispatch_reg;
                            strobe_next                = 1'b1;
                            result_next.previous_level = level_reg;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                result_next.last = 1'b1;
                if (hit)
                begin
                    if (cmd_reg.kind == KIND_INSERT)
                    begin
                        // duplicate key, stored arguments untouched
                        strobe_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (at_end)
                    begin
                        occ_next              = occ_reg - OW'(1);
                        strobe_next           = 1'b1;
                        result_next.done_flag = 1'b1;
                        state_next            = ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + IW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (at_end)
                begin
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                    if (cmd_reg.kind == KIND_INSERT)
                    begin
                        if (occ_reg == OCC_FULL)
                        begin
                            result_next.queue_full = 1'b1;
                        end
                        else
                        begin
                            ram_we                = 1'b1;
                            occ_next              = occ_reg + OW'(1);
                            result_next.done_flag = 1'b1;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            ST_SHIFT:
            begin
                // move each later entry down by one slot
                ram_we    = 1'b1;
                ram_waddr = scan_reg - IW'(1);
                ram_wdata = ram_rdata;
                if (at_end)
                begin
                    occ_next              = occ_reg - OW'(1);
                    strobe_next           = 1'b1;
                    result_next.done_flag = 1'b1;
                    result_next.last      = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            ST_DRAIN:
            begin
                strobe_next              = 1'b1;
                result_next.entry_valid  = 1'b1;
                result_next.entry_key    = ram_rdata.key;
                result_next.entry_first  = ram_rdata.first;
                result_next.entry_second = ram_rdata.second;
                result_next.last         = at_end;
                if (at_end)
                begin
                    occ_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_reg     <= '0;
            occ_reg      <= '0;
            level_reg    <= '0;
            dispatch_reg <= DISPATCH_RESET;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            occ_reg    <= occ_next;
            level_reg  <= level_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                dispatch_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== sv/dcq_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module dcq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/dcq_checker.sv =====
// port-level checks for the deferred-call queue, bound to the top level
// depends on dcq_pkg and deferred_call_queue_with_level_gate
`default_nettype none

module dcq_checker
    import dcq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      busy,
    input wire logic      result_valid,
    input wire out_item_t result
);

    // a request that raises busy ends with its last item
    a_busy_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("busy dropped without a last item");

    // more drained items to come keeps the block busy
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-last item while idle");

    // only drain items may come without last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.entry_valid) |-> result.last)
        else $error("status item without last");

    a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.entry_valid) |->
            (!result.done_flag && !result.queue_full && (result.previous_level == '0)))
        else $error("drain item carries status fields");

    a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.done_flag && result.queue_full))
        else $error("done and full together");

endmodule

bind deferred_call_queue_with_level_gate dcq_checker u_dcq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire
